// File: hdl/tif_pkg.sv
package tif_pkg;

   // telnet command and character codes
   localparam logic [7:0] TN_IAC     = 8'd255;
   localparam logic [7:0] TN_DONT    = 8'd254;
   localparam logic [7:0] TN_DO      = 8'd253;
   localparam logic [7:0] TN_WONT    = 8'd252;
   localparam logic [7:0] TN_WILL    = 8'd251;
   localparam logic [7:0] TN_SB      = 8'd250;
   localparam logic [7:0] TN_CMD_LOW = 8'd236;
   localparam logic [7:0] TN_SE      = 8'd240;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_LF      = 8'd10;

   // configuration register indexes and reset values
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPTION_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPTION_B = 2'd1;
   localparam logic [7:0] OPTION_A_RESET = 8'd1;
   localparam logic [7:0] OPTION_B_RESET = 8'd3;

   // result destinations
   localparam logic DEST_TERMINAL = 1'b0;
   localparam logic DEST_PEER     = 1'b1;

   // work queue sizing
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic       destination;
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // one input byte's worth of results, up to three bytes, one destination
   typedef struct packed {
      logic [1:0] count;
      logic       dest;
      logic [7:0] byte_2;
      logic [7:0] byte_1;
      logic [7:0] byte_0;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hdl/tif_front.sv
module tif_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tif_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tif_pkg::req_type                 req_data,
   input  tif_pkg::q_status_type            q_status,
   output logic                             push,
   output tif_pkg::work_type                push_entry
);

   typedef enum logic [1:0] {
      MODE_DATA,
      MODE_IAC,
      MODE_VERB,
      MODE_SUB
   } mode_type;

   typedef enum logic [1:0] {
      VERB_DO,
      VERB_WILL,
      VERB_DONT,
      VERB_WONT
   } verb_type;

   typedef struct packed {
      tif_pkg::work_type work;
      logic              cr;
   } dp_type;

   mode_type   mode_ff, mode_in;
   verb_type   verb_ff, verb_in;
   logic       cr_ff, cr_in;
   logic [7:0] opt_a_ff, opt_b_ff;
   logic       accept;
   logic       opt_ok;
   dp_type     dp;
   tif_pkg::work_type work;

   // plain data handling with CR/LF folding
   function automatic dp_type data_path(input logic cr, input logic [7:0] b, input logic eoc);
      dp_type r;
      r = '0;
      r.work.dest = tif_pkg::DEST_TERMINAL;
      if (cr) begin
         if (b == tif_pkg::CH_LF) begin
            r.work.count  = 2'd1;
            r.work.byte_0 = tif_pkg::CH_LF;
         end else if (b == tif_pkg::CH_CR) begin
            r.work.byte_0 = tif_pkg::CH_CR;
            if (eoc) begin
               r.work.count  = 2'd2;
               r.work.byte_1 = tif_pkg::CH_CR;
            end else begin
               r.work.count = 2'd1;
               r.cr         = 1'b1;
            end
         end else begin
            r.work.count  = 2'd2;
            r.work.byte_0 = tif_pkg::CH_CR;
            r.work.byte_1 = b;
         end
      end else if (b == tif_pkg::CH_CR) begin
         if (eoc) begin
            r.work.count  = 2'd1;
            r.work.byte_0 = tif_pkg::CH_CR;
         end else begin
            r.cr = 1'b1;
         end
      end else begin
         r.work.count  = 2'd1;
         r.work.byte_0 = b;
      end
      return r;
   endfunction

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign opt_ok    = (req_data.in_byte == opt_a_ff) || (req_data.in_byte == opt_b_ff);
   assign dp        = data_path(cr_ff, req_data.in_byte, req_data.end_of_chunk);

   // classify the incoming byte against the parse state
   always_comb begin
      mode_in = mode_ff;
      verb_in = verb_ff;
      cr_in   = cr_ff;
      work    = '0;
      unique case (mode_ff)
         MODE_IAC: begin
            mode_in = MODE_DATA;
            priority if (req_data.in_byte == tif_pkg::TN_IAC) begin
               work.count  = 2'd1;
               work.dest   = tif_pkg::DEST_TERMINAL;
               work.byte_0 = tif_pkg::TN_IAC;
            end else if (req_data.in_byte == tif_pkg::TN_DO) begin
               verb_in = VERB_DO;
               mode_in = MODE_VERB;
            end else if (req_data.in_byte == tif_pkg::TN_WILL) begin
               verb_in = VERB_WILL;
               mode_in = MODE_VERB;
            end else if (req_data.in_byte == tif_pkg::TN_DONT) begin
               verb_in = VERB_DONT;
               mode_in = MODE_VERB;
            end else if (req_data.in_byte == tif_pkg::TN_WONT) begin
               verb_in = VERB_WONT;
               mode_in = MODE_VERB;
            end else if (req_data.in_byte == tif_pkg::TN_SB) begin
               mode_in = MODE_SUB;
            end else if (req_data.in_byte >= tif_pkg::TN_CMD_LOW) begin
               // two-byte command: drop it
            end else begin
               work  = dp.work;
               cr_in = dp.cr;
            end
         end
         MODE_VERB: begin
            mode_in = MODE_DATA;
            if (verb_ff == VERB_DO || verb_ff == VERB_WILL) begin
               work.count  = 2'd3;
               work.dest   = tif_pkg::DEST_PEER;
               work.byte_0 = tif_pkg::TN_IAC;
               work.byte_2 = req_data.in_byte;
               if (verb_ff == VERB_DO) begin
                  work.byte_1 = opt_ok ? tif_pkg::TN_WILL : tif_pkg::TN_WONT;
               end else begin
                  work.byte_1 = opt_ok ? tif_pkg::TN_DO : tif_pkg::TN_DONT;
               end
            end
         end
         MODE_SUB: begin
            if (req_data.in_byte == tif_pkg::TN_SE) begin
               mode_in = MODE_DATA;
            end
         end
         MODE_DATA: begin
            if (req_data.in_byte == tif_pkg::TN_IAC) begin
               // flush a held CR before the command starts
               if (cr_ff) begin
                  work.count  = 2'd1;
                  work.dest   = tif_pkg::DEST_TERMINAL;
                  work.byte_0 = tif_pkg::CH_CR;
               end
               cr_in   = 1'b0;
               mode_in = MODE_IAC;
            end else begin
               work  = dp.work;
               cr_in = dp.cr;
            end
         end
         default: mode_in = MODE_DATA;
      endcase
   end

   assign push       = accept && (work.count != 2'd0);
   assign push_entry = work;

   // hold parse state and option registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DATA;
         verb_ff  <= VERB_DO;
         cr_ff    <= 1'b0;
         opt_a_ff <= tif_pkg::OPTION_A_RESET;
         opt_b_ff <= tif_pkg::OPTION_B_RESET;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            verb_ff <= verb_in;
            cr_ff   <= cr_in;
         end
         if (csr_we && csr_index == tif_pkg::CSR_OPTION_A) begin
            opt_a_ff <= csr_wdata;
         end
         if (csr_we && csr_index == tif_pkg::CSR_OPTION_B) begin
            opt_b_ff <= csr_wdata;
         end
      end
   end

`ifndef ASSERT_OFF
   // a CR is only held while in plain data mode
   a_cr_in_data: assert property (@(posedge clock) disable iff (reset)
      cr_ff |-> (mode_ff == MODE_DATA))
      else $error("CR held outside data mode");
   // replies toward the peer are always three bytes
   a_reply_len: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.dest == tif_pkg::DEST_PEER) |-> (push_entry.count == 2'd3))
      else $error("peer reply of wrong length");
`endif

endmodule

// File: hdl/tif_queue.sv
module tif_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tif_pkg::work_type     push_entry,
   input  logic                  pop,
   output tif_pkg::work_type     head_entry,
   output tif_pkg::q_status_type q_status
);

   tif_pkg::work_type               entries_ff [tif_pkg::QUEUE_DEPTH];
   logic [tif_pkg::QPTR_W-1:0]      head_ff, head_in;
   logic [tif_pkg::QPTR_W-1:0]      tail_ff, tail_in;
   logic [tif_pkg::QCNT_W-1:0]      count_ff, count_in;

   function automatic logic [tif_pkg::QPTR_W-1:0] ptr_next(input logic [tif_pkg::QPTR_W-1:0] p);
      return (p == tif_pkg::QPTR_W'(tif_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_status.full  = (count_ff == tif_pkg::QCNT_W'(tif_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_entry     = entries_ff[head_ff];

   // advance pointers and occupancy
   always_comb begin
      head_in  = pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // store the entry at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tif_pkg::QCNT_W'(tif_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// File: hdl/tif_back.sv
module tif_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tif_pkg::work_type     head_entry,
   input  tif_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tif_pkg::rsp_type      rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       beat;
   logic       last;

   assign rsp_valid = !q_status.empty;
   assign beat      = rsp_valid && rsp_ready;
   assign last      = (idx_ff == head_entry.count - 2'd1);
   assign pop       = beat && last;

   // pick the byte of the head entry under the index
   always_comb begin
      rsp_data.destination = head_entry.dest;
      rsp_data.last_of_run = last;
      unique case (idx_ff)
         2'd1:    rsp_data.out_byte = head_entry.byte_1;
         2'd2:    rsp_data.out_byte = head_entry.byte_2;
         default: rsp_data.out_byte = head_entry.byte_0;
      endcase
   end

   // step through the entry one beat at a time
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = 2'd0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

`ifndef ASSERT_OFF
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < head_entry.count))
      else $error("result index past entry length");
`endif

endmodule

// File: hdl/telnet_inbound_filter_top.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  tif_pkg::req_type (in_byte, end_of_chunk)
// rsp      out        rsp_valid / rsp_ready  tif_pkg::rsp_type (destination, out_byte, last_of_run)
// csr      in         csr_we                 csr_index (2 bits), csr_wdata (8 bits)
//
// An input byte is classified in the cycle it is accepted; one byte per cycle is taken
// while req_ready is high, which drops only when the queue is full. Its results (0 to 3
// bytes, three for a negotiation reply) leave one per cycle as rsp_ready allows, via a
// four-entry work queue that absorbs the difference. From empty, it offers a result next cycle.
// Synchronous reset clears parse state, queue and output index; options return to 1 and 3.
module telnet_inbound_filter_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tif_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tif_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [tif_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata
);

   logic                  push;
   logic                  pop;
   tif_pkg::work_type     push_entry;
   tif_pkg::work_type     head_entry;
   tif_pkg::q_status_type q_status;

   tif_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   tif_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   tif_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: bench/telnet_filter_checker.sv
module telnet_filter_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  tif_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  tif_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [tif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      MODE_PLAIN     = 3'd0,
      MODE_AFTER_IAC = 3'd1,
      MODE_OPTION    = 3'd2,
      MODE_SUBNEG    = 3'd3
   } parse_mode_type;

   typedef enum logic [1:0] {
      VERB_DO   = 2'd0,
      VERB_WILL = 2'd1,
      VERB_DONT = 2'd2,
      VERB_WONT = 2'd3
   } verb_type;

   parse_mode_type link_mode   = MODE_PLAIN;
   verb_type       held_verb   = VERB_DO;
   logic           cr_waiting  = 1'b0;
   logic [7:0]     option_a    = tif_pkg::OPTION_A_RESET;
   logic [7:0]     option_b    = tif_pkg::OPTION_B_RESET;

   tif_pkg::rsp_type expected_bytes[$];
   tif_pkg::rsp_type beat_bytes[$];
   int               mismatches = 0;

   task automatic note_mismatch(input string msg);
      $display("%0t ns: rsp mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void emit_byte(input logic dest, input logic [7:0] value);
      tif_pkg::rsp_type r;
      r.destination = dest;
      r.out_byte    = value;
      r.last_of_run = 1'b0;
      beat_bytes.push_back(r);
   endfunction

   // CR/LF folding for bytes headed to the terminal
   function automatic void terminal_byte(input logic [7:0] value, input logic eoc);
      if (cr_waiting) begin
         cr_waiting = 1'b0;
         if (value == tif_pkg::CH_LF) begin
            emit_byte(tif_pkg::DEST_TERMINAL, tif_pkg::CH_LF);
            return;
         end
         emit_byte(tif_pkg::DEST_TERMINAL, tif_pkg::CH_CR);
      end
      if (value == tif_pkg::CH_CR) begin
         if (eoc)
            emit_byte(tif_pkg::DEST_TERMINAL, tif_pkg::CH_CR);
         else
            cr_waiting = 1'b1;
      end else begin
         emit_byte(tif_pkg::DEST_TERMINAL, value);
      end
   endfunction

   // Advance the parser by one accepted byte and queue the bytes it produces
   function automatic void filter_beat(input tif_pkg::req_type beat);
      logic [7:0] value;
      logic       agreed;
      value = beat.in_byte;
      beat_bytes.delete();
      case (link_mode)
         MODE_AFTER_IAC: begin
            link_mode = MODE_PLAIN;
            if (value == tif_pkg::TN_IAC) begin
               emit_byte(tif_pkg::DEST_TERMINAL, tif_pkg::TN_IAC);
            end else if (value == tif_pkg::TN_DO) begin
               held_verb = VERB_DO;
               link_mode = MODE_OPTION;
            end else if (value == tif_pkg::TN_WILL) begin
               held_verb = VERB_WILL;
               link_mode = MODE_OPTION;
            end else if (value == tif_pkg::TN_DONT) begin
               held_verb = VERB_DONT;
               link_mode = MODE_OPTION;
            end else if (value == tif_pkg::TN_WONT) begin
               held_verb = VERB_WONT;
               link_mode = MODE_OPTION;
            end else if (value == tif_pkg::TN_SB) begin
               link_mode = MODE_SUBNEG;
            end else if (value >= tif_pkg::TN_CMD_LOW && value <= tif_pkg::TN_SB - 8'd1) begin
               // two-byte command: drop
            end else begin
               terminal_byte(value, beat.end_of_chunk);
            end
         end
         MODE_OPTION: begin
            agreed    = (value == option_a) || (value == option_b);
            link_mode = MODE_PLAIN;
            if (held_verb == VERB_DO || held_verb == VERB_WILL) begin
               emit_byte(tif_pkg::DEST_PEER, tif_pkg::TN_IAC);
               if (held_verb == VERB_DO)
                  emit_byte(tif_pkg::DEST_PEER, agreed ? tif_pkg::TN_WILL : tif_pkg::TN_WONT);
               else
                  emit_byte(tif_pkg::DEST_PEER, agreed ? tif_pkg::TN_DO : tif_pkg::TN_DONT);
               emit_byte(tif_pkg::DEST_PEER, value);
            end
         end
         MODE_SUBNEG: begin
            if (value == tif_pkg::TN_SE)
               link_mode = MODE_PLAIN;
         end
         default: begin
            link_mode = MODE_PLAIN;
            if (value == tif_pkg::TN_IAC) begin
               // flush a held CR before the command starts
               if (cr_waiting) begin
                  cr_waiting = 1'b0;
                  emit_byte(tif_pkg::DEST_TERMINAL, tif_pkg::CH_CR);
               end
               link_mode = MODE_AFTER_IAC;
            end else begin
               terminal_byte(value, beat.end_of_chunk);
            end
         end
      endcase
      if (beat_bytes.size() > 0)
         beat_bytes[beat_bytes.size()-1].last_of_run = 1'b1;
      foreach (beat_bytes[i])
         expected_bytes.push_back(beat_bytes[i]);
   endfunction

   always @(posedge clock) begin : watch
      tif_pkg::rsp_type got;
      tif_pkg::rsp_type want;
      if (reset) begin
         link_mode  = MODE_PLAIN;
         held_verb  = VERB_DO;
         cr_waiting = 1'b0;
         option_a   = tif_pkg::OPTION_A_RESET;
         option_b   = tif_pkg::OPTION_B_RESET;
         expected_bytes.delete();
      end else begin
         // track option registers
         if (csr_we) begin
            case (csr_index)
               tif_pkg::CSR_OPTION_A: option_a = csr_wdata;
               tif_pkg::CSR_OPTION_B: option_b = csr_wdata;
               default: ;
            endcase
         end

         // compare an accepted rsp beat with the oldest prediction
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got = rsp_data;
            if (expected_bytes.size() == 0) begin
               note_mismatch($sformatf("unexpected beat dest %0d byte %0d last %0d",
                                       got.destination, got.out_byte, got.last_of_run));
            end else begin
               want = expected_bytes.pop_front();
               if (got.destination !== want.destination)
                  note_mismatch($sformatf("destination got %0d expected %0d",
                                          got.destination, want.destination));
               if (got.out_byte !== want.out_byte)
                  note_mismatch($sformatf("out_byte got %0d expected %0d",
                                          got.out_byte, want.out_byte));
               if (got.last_of_run !== want.last_of_run)
                  note_mismatch($sformatf("last_of_run got %0d expected %0d",
                                          got.last_of_run, want.last_of_run));
            end
         end

         // predict the bytes caused by an accepted req beat
         if (req_valid && req_ready === 1'b1)
            filter_beat(req_data);
      end
      pending_count <= expected_bytes.size();
      fail_count    <= mismatches;
   end

endmodule

// File: bench/telnet_inbound_filter_top_tb.sv
module telnet_inbound_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE      = 6;
   localparam logic [tif_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [tif_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   tif_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   tif_pkg::rsp_type                rsp_data;
   logic                            csr_we    = 1'b0;
   logic [tif_pkg::CSR_INDEX_W-1:0] csr_index = tif_pkg::CSR_OPTION_A;
   logic [7:0]                      csr_wdata = '0;

   int         fail_count;
   int         pending_count;
   int         sent_items  = 0;
   int         hold_asked  = 0;
   int         hold_served = 0;
   bit         steady      = 1'b0;
   logic [7:0] cfg_a       = tif_pkg::OPTION_A_RESET;
   logic [7:0] cfg_b       = tif_pkg::OPTION_B_RESET;

   telnet_inbound_filter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   telnet_filter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // End the run if it stalls
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Mostly short gaps, a few long ones, none while running steady
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int gap;
      forever begin
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Offer one req beat after a random gap and hold it until accepted
   task automatic send_beat(input logic [7:0] value, input logic eoc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_data.in_byte      <= value;
      req_data.end_of_chunk <= eoc;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      sent_items++;
   endtask

   function automatic logic random_eoc();
      return ($urandom_range(0, 3) == 0);
   endfunction

   // One random unit: mostly well-formed telnet sequences, some noise
   task automatic send_unit();
      int         r;
      int         len;
      logic [7:0] value;
      logic [7:0] verb;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         case ($urandom_range(0, 5))
            0:       value = tif_pkg::CH_CR;
            1:       value = tif_pkg::CH_LF;
            default: value = 8'($urandom_range(0, tif_pkg::TN_IAC - 8'd1));
         endcase
         send_beat(value, random_eoc());
      end else if (r < 40) begin
         send_beat(tif_pkg::CH_CR, random_eoc());
         send_beat(tif_pkg::CH_LF, random_eoc());
      end else if (r < 60) begin
         case ($urandom_range(0, 3))
            0:       verb = tif_pkg::TN_DO;
            1:       verb = tif_pkg::TN_WILL;
            2:       verb = tif_pkg::TN_DONT;
            default: verb = tif_pkg::TN_WONT;
         endcase
         case ($urandom_range(0, 2))
            0:       value = cfg_a;
            1:       value = cfg_b;
            default: value = 8'($urandom_range(0, 255));
         endcase
         send_beat(tif_pkg::TN_IAC, random_eoc());
         send_beat(verb, random_eoc());
         send_beat(value, random_eoc());
      end else if (r < 67) begin
         send_beat(tif_pkg::TN_IAC, random_eoc());
         send_beat(tif_pkg::TN_IAC, random_eoc());
      end else if (r < 75) begin
         // subnegotiation body may hold IAC, only SE closes it
         send_beat(tif_pkg::TN_IAC, random_eoc());
         send_beat(tif_pkg::TN_SB, random_eoc());
         len = $urandom_range(0, 5);
         repeat (len) begin
            value = 8'($urandom_range(0, 255));
            if (value == tif_pkg::TN_SE)
               value = tif_pkg::TN_IAC;
            send_beat(value, random_eoc());
         end
         send_beat(tif_pkg::TN_SE, random_eoc());
      end else if (r < 82) begin
         send_beat(tif_pkg::TN_IAC, random_eoc());
         send_beat(8'($urandom_range(tif_pkg::TN_CMD_LOW, tif_pkg::TN_SB - 8'd1)),
                   random_eoc());
      end else if (r < 90) begin
         send_beat(tif_pkg::TN_IAC, random_eoc());
         send_beat(8'($urandom_range(0, tif_pkg::TN_CMD_LOW - 8'd1)), random_eoc());
      end else begin
         send_beat(8'($urandom_range(0, 255)), random_eoc());
      end
   endtask

   task automatic random_phase(input int count);
      int start;
      start = sent_items;
      while (sent_items - start < count)
         send_unit();
   endtask

   // Stop offering and wait until every predicted byte has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write both options and one unused index, only while idle
   task automatic set_options(input logic [7:0] a, input logic [7:0] b);
      csr_we    <= 1'b1;
      csr_index <= tif_pkg::CSR_OPTION_A;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= tif_pkg::CSR_OPTION_B;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= ($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_wdata <= 8'($urandom_range(0, 255));
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_a = a;
      cfg_b = b;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] same;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: data extremes and CR handling
      send_beat(8'h00, 1'b0);
      send_beat(tif_pkg::TN_DONT, 1'b1);
      send_beat(tif_pkg::CH_CR, 1'b0);
      send_beat(tif_pkg::CH_LF, 1'b0);
      send_beat(tif_pkg::CH_CR, 1'b0);
      send_beat(8'h78, 1'b0);
      send_beat(tif_pkg::CH_CR, 1'b1);
      // held CR flushed by IAC, then escaped 255
      send_beat(tif_pkg::CH_CR, 1'b0);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      // negotiation at reset options
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_DO, 1'b0);
      send_beat(tif_pkg::OPTION_A_RESET, 1'b0);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_WILL, 1'b1);
      send_beat(8'hC8, 1'b1);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_DONT, 1'b0);
      send_beat(tif_pkg::OPTION_B_RESET, 1'b0);
      // subnegotiation with an IAC inside, end of chunk ignored
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_SB, 1'b1);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_SE, 1'b0);
      // two-byte command, then unknown command carrying a CR
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::TN_CMD_LOW, 1'b0);
      send_beat(tif_pkg::TN_IAC, 1'b0);
      send_beat(tif_pkg::CH_CR, 1'b0);
      send_beat(tif_pkg::CH_LF, 1'b0);
      drain_results();

      // receiver holds off long enough to fill the work queue
      set_options(8'd0, 8'd255);
      hold_asked++;
      random_phase(50);
      drain_results();

      // both sides flat out
      set_options(8'd255, 8'd0);
      steady = 1'b1;
      random_phase(50);
      steady = 1'b0;
      drain_results();

      // sender pauses midway until every result has come
      set_options(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase(25);
      drain_results();
      random_phase(25);
      drain_results();

      same = 8'($urandom_range(0, 255));
      set_options(same, same);
      random_phase(50);
      drain_results();

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
